// File: design/approx_time_pair_matcher_macros.svh
// Assertion helpers shared by the matcher modules.
`ifndef APPROX_TIME_PAIR_MATCHER_MACROS_SVH
`define APPROX_TIME_PAIR_MATCHER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATPM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/atpm_pkg.sv
package atpm_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths
	localparam int TIME_W     = 48;
	localparam int TAG_W      = 16;
	localparam int GAP_W      = 24;
	localparam int LIMIT_W    = 6;
	localparam int SLOP_W     = 24;
	localparam int MIN_W      = 26;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 26;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOP         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

	// Register reset values
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd20;
	localparam logic [SLOP_W-1:0]  SLOP_RESET  = 24'd200000;
	localparam logic [MIN_W-1:0]   MIN_RESET   = 26'd1000000;

	typedef enum logic [1:0] {
		OP_CAMERA = 2'd0,
		OP_LIDAR  = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic clear_busy;
		logic push;
		logic search_init;
		logic cam_rd;
		logic lid_step;
		logic next_cam;
		logic tag_rd;
		logic commit;
		logic load_out;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic start_ok;
		logic lid_last;
		logic cam_last;
		logic found;
	} sts_t;

endpackage

// File: design/approx_time_pair_matcher.sv
// Finish and unused operations go straight to the result; a plain arrival is pushed and
// start-checked first. An arrival that searches then scans each camera entry against the whole
// lidar queue, one lidar entry read per cycle, then fetches the tags and commits on a match.
// Throughput: one transaction at a time, next accepted the cycle after the result loads.
// Reset (arst_n low, asynchronous) empties both queues, clears busy and start time,
// and restores the register defaults.
module approx_time_pair_matcher (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [atpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          operation,
	input  logic [atpm_pkg::TIME_W-1:0]         arrival_time_us,
	input  logic [atpm_pkg::TAG_W-1:0]          cloud_tag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                pair_started,
	output logic [atpm_pkg::TAG_W-1:0]          camera_tag,
	output logic [atpm_pkg::TAG_W-1:0]          lidar_tag,
	output logic [atpm_pkg::GAP_W-1:0]          pair_gap_us
);

	atpm_pkg::cmd_t cmd;
	atpm_pkg::sts_t sts;

	// Sequencer
	atpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Queues, search and result
	atpm_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.arrival_time_us (arrival_time_us),
		.cloud_tag       (cloud_tag),
		.cmd             (cmd),
		.sts             (sts),
		.pair_started    (pair_started),
		.camera_tag      (camera_tag),
		.lidar_tag       (lidar_tag),
		.pair_gap_us     (pair_gap_us)
	);

endmodule

// File: design/atpm_ctrl.sv
`include "approx_time_pair_matcher_macros.svh"

module atpm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	output logic                out_valid,
	input  logic                out_stall,
	output atpm_pkg::cmd_t      cmd,
	input  atpm_pkg::sts_t      sts
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_CHECK,
		S_CAM_RD,
		S_LID_SCAN,
		S_NEXT_CAM,
		S_TAG_RD,
		S_COMMIT,
		S_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   is_arrival;

	assign is_arrival = (operation == atpm_pkg::OP_CAMERA) || (operation == atpm_pkg::OP_LIDAR);
	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture    = in_valid;
				cmd.clear_busy = in_valid && (operation == atpm_pkg::OP_FINISH);
			end
			S_PUSH:     cmd.push        = 1'b1;
			S_CHECK:    cmd.search_init = sts.start_ok;
			S_CAM_RD:   cmd.cam_rd      = 1'b1;
			S_LID_SCAN: cmd.lid_step    = 1'b1;
			S_NEXT_CAM: cmd.next_cam    = 1'b1;
			S_TAG_RD:   cmd.tag_rd      = 1'b1;
			S_COMMIT:   cmd.commit      = 1'b1;
			S_FIN:      cmd.load_out    = !out_valid_q || !out_stall;
			default:    cmd = '0;
		endcase
	end

	// Advance the sequencer and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= is_arrival ? S_PUSH : S_FIN;
					end
				end
				S_PUSH:  state_q <= S_CHECK;
				S_CHECK: state_q <= sts.start_ok ? S_CAM_RD : S_FIN;
				S_CAM_RD: state_q <= S_LID_SCAN;
				S_LID_SCAN: begin
					if (sts.lid_last) begin
						state_q <= S_NEXT_CAM;
					end
				end
				S_NEXT_CAM: state_q <= sts.cam_last ? S_TAG_RD : S_CAM_RD;
				S_TAG_RD:   state_q <= sts.found ? S_COMMIT : S_FIN;
				S_COMMIT:   state_q <= S_FIN;
				S_FIN: begin
					if (cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ATPM_ASSERT_IMP(a_load_free, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall, "result loaded over a pending transaction")
	`ATPM_ASSERT_NXT(a_finish_path, clk, arst_n, in_valid && !in_stall && !is_arrival, state_q == S_FIN, "non-arrival transaction did not go straight to result")
	`ATPM_ASSERT_IMP(a_check_after_push, clk, arst_n, state_q == S_CHECK, $past(state_q) == S_PUSH, "start check without a preceding push")

endmodule

// File: design/atpm_dp.sv
`include "approx_time_pair_matcher_macros.svh"

module atpm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [atpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [atpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                          operation,
	input  logic [atpm_pkg::TIME_W-1:0]         arrival_time_us,
	input  logic [atpm_pkg::TAG_W-1:0]          cloud_tag,
	input  atpm_pkg::cmd_t                      cmd,
	output atpm_pkg::sts_t                      sts,
	output logic                                pair_started,
	output logic [atpm_pkg::TAG_W-1:0]          camera_tag,
	output logic [atpm_pkg::TAG_W-1:0]          lidar_tag,
	output logic [atpm_pkg::GAP_W-1:0]          pair_gap_us
);

	typedef struct packed {
		logic [atpm_pkg::TIME_W-1:0] time_us;
		logic [atpm_pkg::TAG_W-1:0]  tag;
	} entry_t;

	typedef struct packed {
		atpm_pkg::ptr_t head;
		atpm_pkg::cnt_t count;
		atpm_pkg::ptr_t slot;
	} push_t;

	typedef logic [atpm_pkg::CNT_W:0]  sum_t;
	typedef logic [atpm_pkg::TIME_W:0] diff_t;

	// Circular pointer add, offset never above the depth
	function automatic atpm_pkg::ptr_t ptr_add(atpm_pkg::ptr_t base, atpm_pkg::cnt_t off);
		sum_t sum;
		sum = sum_t'(base) + sum_t'(off);
		if (sum >= sum_t'(atpm_pkg::QUEUE_DEPTH)) begin
			sum = sum - sum_t'(atpm_pkg::QUEUE_DEPTH);
		end
		return sum[atpm_pkg::PTR_W-1:0];
	endfunction

	// Zero acts as one, anything above the depth acts as the depth
	function automatic atpm_pkg::cnt_t clamp_limit(logic [atpm_pkg::LIMIT_W-1:0] v);
		atpm_pkg::cnt_t r;
		if (v == '0) begin
			r = atpm_pkg::cnt_t'(1);
		end else if (32'(v) > 32'(atpm_pkg::QUEUE_DEPTH)) begin
			r = atpm_pkg::cnt_t'(atpm_pkg::QUEUE_DEPTH);
		end else begin
			r = atpm_pkg::cnt_t'(v);
		end
		return r;
	endfunction

	// Push one entry: drop oldest when full, then trim to the limit
	function automatic push_t push_calc(atpm_pkg::ptr_t head, atpm_pkg::cnt_t count,
			atpm_pkg::cnt_t lim);
		atpm_pkg::ptr_t h1;
		atpm_pkg::cnt_t c1;
		atpm_pkg::cnt_t c2;
		push_t          r;
		if (count == atpm_pkg::cnt_t'(atpm_pkg::QUEUE_DEPTH)) begin
			h1 = ptr_add(head, atpm_pkg::cnt_t'(1));
			c1 = atpm_pkg::cnt_t'(atpm_pkg::QUEUE_DEPTH - 1);
		end else begin
			h1 = head;
			c1 = count;
		end
		r.slot = ptr_add(h1, c1);
		c2     = c1 + atpm_pkg::cnt_t'(1);
		if (c2 > lim) begin
			r.head  = ptr_add(h1, c2 - lim);
			r.count = lim;
		end else begin
			r.head  = h1;
			r.count = c2;
		end
		return r;
	endfunction

	// Configuration
	logic [atpm_pkg::LIMIT_W-1:0] cfg_limit_q;
	logic [atpm_pkg::SLOP_W-1:0]  cfg_slop_q;
	logic [atpm_pkg::MIN_W-1:0]   cfg_min_q;

	// Captured transaction
	logic [1:0]                   op_q;
	logic [atpm_pkg::TIME_W-1:0]  now_q;
	logic [atpm_pkg::TAG_W-1:0]   tag_q;

	// Queue state
	entry_t                       cam_mem [atpm_pkg::QUEUE_DEPTH];
	entry_t                       lid_mem [atpm_pkg::QUEUE_DEPTH];
	entry_t                       cam_rdata_q;
	entry_t                       lid_rdata_q;
	atpm_pkg::ptr_t               cam_head_q;
	atpm_pkg::ptr_t               lid_head_q;
	atpm_pkg::cnt_t               cam_count_q;
	atpm_pkg::cnt_t               lid_count_q;
	logic                         busy_q;
	logic [atpm_pkg::TIME_W-1:0]  last_start_q;

	// Search state
	atpm_pkg::cnt_t               i_q;
	atpm_pkg::cnt_t               j_q;
	atpm_pkg::cnt_t               j_s1;
	logic                         v_s1;
	logic [atpm_pkg::GAP_W-1:0]   best_q;
	atpm_pkg::cnt_t               bi_q;
	atpm_pkg::cnt_t               bj_q;
	logic                         found_q;

	// Pending and delivered result
	logic                         pend_started_q;
	logic [atpm_pkg::TAG_W-1:0]   pend_ctag_q;
	logic [atpm_pkg::TAG_W-1:0]   pend_ltag_q;
	logic [atpm_pkg::GAP_W-1:0]   pend_gap_q;
	logic                         out_started_q;
	logic [atpm_pkg::TAG_W-1:0]   out_ctag_q;
	logic [atpm_pkg::TAG_W-1:0]   out_ltag_q;
	logic [atpm_pkg::GAP_W-1:0]   out_gap_q;

	atpm_pkg::cnt_t               lim;
	push_t                        cam_push;
	push_t                        lid_push;
	logic                         push_cam;
	logic                         push_lid;
	logic                         cam_rd_en;
	logic                         lid_rd_en;
	atpm_pkg::ptr_t               cam_raddr;
	atpm_pkg::ptr_t               lid_raddr;
	diff_t                        elapsed;
	logic [atpm_pkg::TIME_W-1:0]  ct;
	logic [atpm_pkg::TIME_W-1:0]  lt;
	logic [atpm_pkg::TIME_W-1:0]  dt;
	logic                         hit;

	assign lim      = clamp_limit(cfg_limit_q);
	assign cam_push = push_calc(cam_head_q, cam_count_q, lim);
	assign lid_push = push_calc(lid_head_q, lid_count_q, lim);
	assign push_cam = cmd.push && (op_q == atpm_pkg::OP_CAMERA);
	assign push_lid = cmd.push && (op_q == atpm_pkg::OP_LIDAR);

	// Read address: scan index during the search, chosen index for the tag fetch
	assign cam_rd_en = cmd.cam_rd || cmd.tag_rd;
	assign lid_rd_en = cmd.lid_step || cmd.tag_rd;
	assign cam_raddr = ptr_add(cam_head_q, cmd.tag_rd ? bi_q : i_q);
	assign lid_raddr = ptr_add(lid_head_q, cmd.tag_rd ? bj_q : j_q);

	// Start check: not busy, both queues non-empty, interval elapsed
	assign elapsed = diff_t'(now_q) - diff_t'(last_start_q);
	assign sts.start_ok = !busy_q && (cam_count_q != '0) && (lid_count_q != '0)
		&& !elapsed[atpm_pkg::TIME_W]
		&& ((elapsed[atpm_pkg::TIME_W-1:atpm_pkg::MIN_W] != '0)
			|| (elapsed[atpm_pkg::MIN_W-1:0] >= cfg_min_q));
	assign sts.lid_last = (j_q == lid_count_q - atpm_pkg::cnt_t'(1));
	assign sts.cam_last = (i_q == cam_count_q - atpm_pkg::cnt_t'(1));
	assign sts.found    = found_q;

	// Gap of the pair in flight; ties take the later pair
	assign ct  = cam_rdata_q.time_us;
	assign lt  = lid_rdata_q.time_us;
	assign dt  = (ct >= lt) ? (ct - lt) : (lt - ct);
	assign hit = v_s1 && (dt[atpm_pkg::TIME_W-1:atpm_pkg::GAP_W] == '0)
		&& (dt[atpm_pkg::GAP_W-1:0] <= best_q);

	// Queue memories
	always_ff @(posedge clk) begin
		if (push_cam) begin
			cam_mem[cam_push.slot] <= {now_q, tag_q};
		end
		if (push_lid) begin
			lid_mem[lid_push.slot] <= {now_q, tag_q};
		end
		if (cam_rd_en) begin
			cam_rdata_q <= cam_mem[cam_raddr];
		end
		if (lid_rd_en) begin
			lid_rdata_q <= lid_mem[lid_raddr];
		end
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			now_q <= arrival_time_us;
			tag_q <= cloud_tag;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_limit_q <= atpm_pkg::LIMIT_RESET;
			cfg_slop_q  <= atpm_pkg::SLOP_RESET;
			cfg_min_q   <= atpm_pkg::MIN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				atpm_pkg::CFG_QUEUE_LIMIT:  cfg_limit_q <= cfg_data[atpm_pkg::LIMIT_W-1:0];
				atpm_pkg::CFG_SLOP:         cfg_slop_q  <= cfg_data[atpm_pkg::SLOP_W-1:0];
				atpm_pkg::CFG_MIN_INTERVAL: cfg_min_q   <= cfg_data[atpm_pkg::MIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Queue pointers, busy flag and start time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_head_q   <= '0;
			cam_count_q  <= '0;
			lid_head_q   <= '0;
			lid_count_q  <= '0;
			busy_q       <= 1'b0;
			last_start_q <= '0;
		end else begin
			if (cmd.clear_busy) begin
				busy_q <= 1'b0;
			end
			if (push_cam) begin
				cam_head_q  <= cam_push.head;
				cam_count_q <= cam_push.count;
			end
			if (push_lid) begin
				lid_head_q  <= lid_push.head;
				lid_count_q <= lid_push.count;
			end
			// Pop each queue through the chosen entry
			if (cmd.commit) begin
				cam_head_q   <= ptr_add(cam_head_q, bi_q + atpm_pkg::cnt_t'(1));
				cam_count_q  <= cam_count_q - (bi_q + atpm_pkg::cnt_t'(1));
				lid_head_q   <= ptr_add(lid_head_q, bj_q + atpm_pkg::cnt_t'(1));
				lid_count_q  <= lid_count_q - (bj_q + atpm_pkg::cnt_t'(1));
				busy_q       <= 1'b1;
				last_start_q <= now_q;
			end
		end
	end

	// Pair search indexes and best candidate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q     <= '0;
			j_q     <= '0;
			j_s1    <= '0;
			v_s1    <= 1'b0;
			best_q  <= '0;
			bi_q    <= '0;
			bj_q    <= '0;
			found_q <= 1'b0;
		end else begin
			v_s1 <= cmd.lid_step;
			j_s1 <= j_q;
			if (cmd.search_init) begin
				i_q     <= '0;
				j_q     <= '0;
				best_q  <= cfg_slop_q;
				found_q <= 1'b0;
			end
			if (cmd.lid_step) begin
				j_q <= j_q + atpm_pkg::cnt_t'(1);
			end
			if (cmd.next_cam) begin
				i_q <= i_q + atpm_pkg::cnt_t'(1);
				j_q <= '0;
			end
			if (hit) begin
				best_q  <= dt[atpm_pkg::GAP_W-1:0];
				bi_q    <= i_q;
				bj_q    <= j_s1;
				found_q <= 1'b1;
			end
		end
	end

	// Pending result: cleared per transaction, filled on a start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_started_q <= 1'b0;
			pend_ctag_q    <= '0;
			pend_ltag_q    <= '0;
			pend_gap_q     <= '0;
		end else if (cmd.capture) begin
			pend_started_q <= 1'b0;
			pend_ctag_q    <= '0;
			pend_ltag_q    <= '0;
			pend_gap_q     <= '0;
		end else if (cmd.commit) begin
			pend_started_q <= 1'b1;
			pend_ctag_q    <= cam_rdata_q.tag;
			pend_ltag_q    <= lid_rdata_q.tag;
			pend_gap_q     <= best_q;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_started_q <= pend_started_q;
			out_ctag_q    <= pend_ctag_q;
			out_ltag_q    <= pend_ltag_q;
			out_gap_q     <= pend_gap_q;
		end
	end

	assign pair_started = out_started_q;
	assign camera_tag   = out_ctag_q;
	assign lidar_tag    = out_ltag_q;
	assign pair_gap_us  = out_gap_q;

	`ATPM_ASSERT_IMP(a_cam_count_bound, clk, arst_n, 1'b1, (cam_count_q <= atpm_pkg::cnt_t'(atpm_pkg::QUEUE_DEPTH)) && (lid_count_q <= atpm_pkg::cnt_t'(atpm_pkg::QUEUE_DEPTH)), "queue count beyond depth")
	`ATPM_ASSERT_IMP(a_commit_found, clk, arst_n, cmd.commit, found_q && !busy_q, "pair committed without a match or while busy")
	`ATPM_ASSERT_NXT(a_commit_busy, clk, arst_n, cmd.commit, busy_q && (last_start_q == $past(now_q)), "start not recorded after commit")

endmodule

// File: verif/approx_time_pair_matcher_test.sv
module approx_time_pair_matcher_test;

	// Local copies of the package depth and widths
	localparam int QUEUE_DEPTH = atpm_pkg::QUEUE_DEPTH;
	localparam int TIME_W      = atpm_pkg::TIME_W;
	localparam int TAG_W       = atpm_pkg::TAG_W;
	localparam int GAP_W       = atpm_pkg::GAP_W;
	localparam int LIMIT_W     = atpm_pkg::LIMIT_W;
	localparam int SLOP_W      = atpm_pkg::SLOP_W;
	localparam int MIN_W       = atpm_pkg::MIN_W;
	localparam int CFG_IDX_W   = atpm_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W  = atpm_pkg::CFG_DATA_W;

	// Opcode outside the defined set; the block must ignore it
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Side select for the predictor queues
	localparam int CAMERA_SIDE = 0;
	localparam int LIDAR_SIDE  = 1;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned HOLD_CYCLES = 600;

	typedef struct packed {
		logic [1:0]        op;
		logic [TIME_W-1:0] t_us;
		logic [TAG_W-1:0]  tag;
	} arrival_t;

	typedef struct packed {
		logic              started;
		logic [TAG_W-1:0]  cam_tag;
		logic [TAG_W-1:0]  lid_tag;
		logic [GAP_W-1:0]  gap;
	} pair_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            operation = '0;
	logic [TIME_W-1:0]     arrival_time_us = '0;
	logic [TAG_W-1:0]      cloud_tag = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  pair_started;
	logic [TAG_W-1:0]      camera_tag;
	logic [TAG_W-1:0]      lidar_tag;
	logic [GAP_W-1:0]      pair_gap_us;

	approx_time_pair_matcher dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.arrival_time_us (arrival_time_us),
		.cloud_tag       (cloud_tag),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pair_started    (pair_started),
		.camera_tag      (camera_tag),
		.lidar_tag       (lidar_tag),
		.pair_gap_us     (pair_gap_us)
	);

	// Predictor state: one circular store per sensor
	logic [TIME_W-1:0] q_time [2][QUEUE_DEPTH];
	logic [TAG_W-1:0]  q_tag [2][QUEUE_DEPTH];
	int                q_head [2] = '{0, 0};
	int                q_fill [2] = '{0, 0};
	bit                align_busy = 1'b0;
	logic [TIME_W-1:0] last_start_us = '0;
	logic [LIMIT_W-1:0] limit_setting = atpm_pkg::LIMIT_RESET;
	logic [SLOP_W-1:0]  slop_setting = atpm_pkg::SLOP_RESET;
	logic [MIN_W-1:0]   min_gap_setting = atpm_pkg::MIN_RESET;

	// Stimulus and scoreboard bookkeeping
	arrival_t     pending_arrivals [$];
	pair_result_t expected_pairs [$];
	arrival_t     next_arrival;
	pair_result_t pair_want;
	pair_result_t pair_pred;
	logic [TIME_W-1:0] clock_us = '0;
	bit           in_taken = 1'b0;
	bit           steady_flow = 1'b0;
	bit           receiver_hold_req = 1'b0;
	bit           receiver_hold_done = 1'b0;
	int unsigned  hold_left = 0;
	int unsigned  items_queued = 0;
	int unsigned  results_seen = 0;
	int unsigned  pairs_started = 0;
	int unsigned  settings_count = 0;
	int unsigned  fail_count = 0;
	int unsigned  cycle_count = 0;

	// Advance the clock
	initial begin
		forever #10 clk = ~clk;
	end

	function automatic bit take_break();
		return !steady_flow && ($urandom_range(99) < 10);
	endfunction

	// Drop up to n oldest entries of one store
	function automatic void drop_oldest(int side, int n);
		if (n > q_fill[side])
			n = q_fill[side];
		q_head[side] = (q_head[side] + n) % QUEUE_DEPTH;
		q_fill[side] -= n;
	endfunction

	// Push an arrival and trim to the effective queue limit
	function automatic void store_arrival(int side, logic [TIME_W-1:0] t_us,
			logic [TAG_W-1:0] tag);
		int lim;
		int slot;
		lim = limit_setting;
		if (lim < 1)
			lim = 1;
		if (lim > QUEUE_DEPTH)
			lim = QUEUE_DEPTH;
		if (q_fill[side] >= QUEUE_DEPTH)
			drop_oldest(side, 1);
		slot = (q_head[side] + q_fill[side]) % QUEUE_DEPTH;
		q_time[side][slot] = t_us;
		q_tag[side][slot] = tag;
		q_fill[side]++;
		if (q_fill[side] > lim)
			drop_oldest(side, q_fill[side] - lim);
	endfunction

	// Search all pairs for the smallest gap within slop; later pair wins ties
	function automatic pair_result_t find_pair(logic [TIME_W-1:0] now_us);
		pair_result_t r;
		logic [TIME_W-1:0] best, ct, lt, dt;
		int bi, bj;
		bit found;
		r = '0;
		bi = 0;
		bj = 0;
		found = 1'b0;
		if (align_busy || q_fill[CAMERA_SIDE] == 0 || q_fill[LIDAR_SIDE] == 0)
			return r;
		if (now_us < last_start_us || now_us - last_start_us < TIME_W'(min_gap_setting))
			return r;
		best = TIME_W'(slop_setting);
		for (int i = 0; i < q_fill[CAMERA_SIDE]; i++) begin
			ct = q_time[CAMERA_SIDE][(q_head[CAMERA_SIDE] + i) % QUEUE_DEPTH];
			for (int j = 0; j < q_fill[LIDAR_SIDE]; j++) begin
				lt = q_time[LIDAR_SIDE][(q_head[LIDAR_SIDE] + j) % QUEUE_DEPTH];
				dt = (ct >= lt) ? ct - lt : lt - ct;
				if (dt <= best) begin
					best = dt;
					bi = i;
					bj = j;
					found = 1'b1;
				end
			end
		end
		if (!found)
			return r;
		r.started = 1'b1;
		r.cam_tag = q_tag[CAMERA_SIDE][(q_head[CAMERA_SIDE] + bi) % QUEUE_DEPTH];
		r.lid_tag = q_tag[LIDAR_SIDE][(q_head[LIDAR_SIDE] + bj) % QUEUE_DEPTH];
		r.gap = best[GAP_W-1:0];
		drop_oldest(CAMERA_SIDE, bi + 1);
		drop_oldest(LIDAR_SIDE, bj + 1);
		align_busy = 1'b1;
		last_start_us = now_us;
		return r;
	endfunction

	function automatic pair_result_t predict_pair(logic [1:0] op, logic [TIME_W-1:0] t_us,
			logic [TAG_W-1:0] tag);
		pair_result_t r;
		r = '0;
		case (op)
			atpm_pkg::OP_CAMERA: begin
				store_arrival(CAMERA_SIDE, t_us, tag);
				r = find_pair(t_us);
			end
			atpm_pkg::OP_LIDAR: begin
				store_arrival(LIDAR_SIDE, t_us, tag);
				r = find_pair(t_us);
			end
			atpm_pkg::OP_FINISH: begin
				align_busy = 1'b0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void check_field(string field, logic [GAP_W-1:0] want,
			logic [GAP_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $realtime, field, want, got);
		end
	endfunction

	function automatic void queue_item(logic [1:0] op, logic [TIME_W-1:0] t_us,
			logic [TAG_W-1:0] tag);
		arrival_t a;
		a.op = op;
		a.t_us = t_us;
		a.tag = tag;
		pending_arrivals = {pending_arrivals, a};
		items_queued++;
	endfunction

	// Random arrivals around a moving clock, with finishes, junk opcodes and time jumps
	function automatic void queue_random(int n, int unsigned step_max);
		int r;
		logic [1:0] op;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 2)
				clock_us = {16'($urandom), 32'($urandom)};
			else if (r < 5)
				clock_us = clock_us - TIME_W'($urandom_range(0, 2 * step_max));
			else
				clock_us = clock_us + TIME_W'($urandom_range(0, 2 * step_max));
			r = $urandom_range(99);
			if (r < 12)
				op = atpm_pkg::OP_FINISH;
			else if (r < 14)
				op = OP_UNUSED;
			else if (r < 57)
				op = atpm_pkg::OP_CAMERA;
			else
				op = atpm_pkg::OP_LIDAR;
			queue_item(op, clock_us, 16'($urandom));
		end
	endfunction

	// Hold until every queued transaction has produced its result
	task automatic wait_drained();
		while (results_seen != items_queued)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write all three registers back to back while idle
	task automatic load_settings(logic [LIMIT_W-1:0] lim, logic [SLOP_W-1:0] slop,
			logic [MIN_W-1:0] min_gap);
		cfg_wr_en <= 1'b1;
		cfg_index <= atpm_pkg::CFG_QUEUE_LIMIT;
		cfg_data <= CFG_DATA_W'(lim);
		@(negedge clk);
		cfg_index <= atpm_pkg::CFG_SLOP;
		cfg_data <= CFG_DATA_W'(slop);
		@(negedge clk);
		cfg_index <= atpm_pkg::CFG_MIN_INTERVAL;
		cfg_data <= CFG_DATA_W'(min_gap);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		limit_setting = lim;
		slop_setting = slop;
		min_gap_setting = min_gap;
		settings_count++;
	endtask

	// Accept input transactions and predict their results
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			pair_pred = predict_pair(operation, arrival_time_us, cloud_tag);
			expected_pairs = {expected_pairs, pair_pred};
		end
	end

	// Drive input transactions; hold a stalled payload
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_arrivals.size() != 0 && !take_break()) begin
				next_arrival = pending_arrivals[0];
				pending_arrivals.delete(0);
				operation <= next_arrival.op;
				arrival_time_us <= next_arrival.t_us;
				cloud_tag <= next_arrival.tag;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Drive the result stall: random idling plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (receiver_hold_req && !receiver_hold_done) begin
			receiver_hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= take_break();
		end
	end

	// Check each result transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_pairs.size() == 0) begin
				fail_count++;
				$display("%0t: result with nothing expected, actual %b %h %h %h", $realtime,
					pair_started, camera_tag, lidar_tag, pair_gap_us);
			end else begin
				pair_want = expected_pairs[0];
				expected_pairs.delete(0);
				check_field("pair_started", GAP_W'(pair_want.started), GAP_W'(pair_started));
				check_field("camera_tag", GAP_W'(pair_want.cam_tag), GAP_W'(camera_tag));
				check_field("lidar_tag", GAP_W'(pair_want.lid_tag), GAP_W'(lidar_tag));
				check_field("pair_gap_us", pair_want.gap, pair_gap_us);
				if (pair_want.started)
					pairs_started++;
			end
		end
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results pending", cycle_count,
			expected_pairs.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [LIMIT_W-1:0] lim;
		logic [SLOP_W-1:0] slop;
		logic [MIN_W-1:0] min_gap;
		int unsigned step;
		int pick;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part under reset defaults
		queue_item(atpm_pkg::OP_FINISH, '0, '0);
		queue_item(OP_UNUSED, '1, '1);
		queue_item(atpm_pkg::OP_CAMERA, 48'd0, 16'h0000);
		queue_item(atpm_pkg::OP_LIDAR, 48'd100, 16'hFFFF);
		queue_item(atpm_pkg::OP_CAMERA, 48'd1_000_000, 16'h0001);
		queue_item(atpm_pkg::OP_LIDAR, 48'd1_050_000, 16'h0002);
		queue_item(atpm_pkg::OP_FINISH, 48'd1_050_000, 16'h1234);
		queue_item(atpm_pkg::OP_LIDAR, 48'd2_000_000, 16'h0003);
		queue_item(atpm_pkg::OP_FINISH, 48'd2_000_000, 16'h0000);
		// gaps beyond slop, then an exact match
		queue_item(atpm_pkg::OP_LIDAR, 48'd2_500_000, 16'h0010);
		queue_item(atpm_pkg::OP_CAMERA, 48'd3_000_000, 16'h0011);
		queue_item(atpm_pkg::OP_LIDAR, 48'd3_000_000, 16'h0012);
		// fill while busy, then too soon, then a tied search
		queue_item(atpm_pkg::OP_CAMERA, 48'd3_500_000, 16'h0020);
		queue_item(atpm_pkg::OP_LIDAR, 48'd3_400_000, 16'h0021);
		queue_item(atpm_pkg::OP_LIDAR, 48'd3_600_000, 16'h0022);
		queue_item(atpm_pkg::OP_FINISH, 48'd3_600_000, 16'hFFFF);
		queue_item(atpm_pkg::OP_CAMERA, 48'd3_950_000, 16'h0023);
		queue_item(atpm_pkg::OP_CAMERA, 48'd4_000_000, 16'h0024);
		queue_item(atpm_pkg::OP_FINISH, 48'd4_000_000, 16'h0000);
		// time behind the last start, then the largest time
		queue_item(atpm_pkg::OP_CAMERA, 48'd10, 16'h0030);
		queue_item(atpm_pkg::OP_LIDAR, '1, 16'h0031);
		queue_item(OP_UNUSED, 48'd0, 16'h0000);

		// Register extremes: zero limit and slop, then oversize limit, then full depth
		clock_us = 48'd5_000_000;
		wait_drained();
		load_settings(6'd0, '0, '0);
		queue_random(40, 3);
		wait_drained();
		load_settings(6'd63, '1, '1);
		queue_random(60, 2_000_000);
		wait_drained();
		load_settings(6'd32, '0, '0);
		queue_random(40, 1000);

		// Random settings, mostly small queues
		for (int p = 0; p < 7; p++) begin
			wait_drained();
			steady_flow = (p == 4);
			if ($urandom_range(9) == 0)
				lim = LIMIT_W'($urandom_range(0, 63));
			else
				lim = LIMIT_W'($urandom_range(1, 8));
			if ($urandom_range(1) == 0)
				slop = SLOP_W'($urandom_range(0, 20000));
			else
				slop = SLOP_W'($urandom);
			step = slop / 2 + 50;
			pick = $urandom_range(99);
			if (pick < 50)
				min_gap = MIN_W'($urandom_range(0, 3 * step));
			else if (pick < 80)
				min_gap = '0;
			else
				min_gap = MIN_W'($urandom);
			load_settings(lim, slop, min_gap);
			if (p == 2)
				receiver_hold_req = 1'b1;
			queue_random(55, step);
		end

		wait_drained();
		steady_flow = 1'b0;
		repeat (20) @(negedge clk);
		$display("Checked %0d transactions under %0d register settings, %0d started pairs.",
			results_seen, settings_count, pairs_started);
		$display("Covered finishes, unused opcodes, tied gaps, time rollback and full stores.");
		if (fail_count == 0 && expected_pairs.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: approx_time_pair_matcher.f
+incdir+design
design/atpm_pkg.sv
design/atpm_ctrl.sv
design/atpm_dp.sv
design/approx_time_pair_matcher.sv
verif/approx_time_pair_matcher_test.sv
